// File: hdl/dac_pkg.sv
package dac_pkg;

  // Fixed field widths of the item and result beats.
  localparam int WORD_W = 15;
  localparam int ADDR_W = 7;
  localparam int OP_W   = 8;

  // An instruction word is opcode * DEC_BASE + location.
  localparam int DEC_BASE = 100;

  // The quotient by DEC_BASE is (w * DEC_RECIP) >> DEC_SHIFT, exact for w below 43699.
  localparam int RECIP_W   = 13;
  localparam int DEC_SHIFT = 19;
  localparam logic [RECIP_W-1:0] DEC_RECIP = 13'd5243;

  typedef enum logic [2:0] {
    ST_RUN   = 3'd0,
    ST_HALT  = 3'd1,
    ST_BADOP = 3'd2,
    ST_OVF   = 3'd3,
    ST_DIV0  = 3'd4,
    ST_END   = 3'd5,
    ST_IDLE  = 3'd6
  } status_t;

  localparam logic [OP_W-1:0] OP_READ   = 8'd10;
  localparam logic [OP_W-1:0] OP_WRITE  = 8'd11;
  localparam logic [OP_W-1:0] OP_LOAD   = 8'd20;
  localparam logic [OP_W-1:0] OP_STORE  = 8'd21;
  localparam logic [OP_W-1:0] OP_ADD    = 8'd30;
  localparam logic [OP_W-1:0] OP_SUB    = 8'd31;
  localparam logic [OP_W-1:0] OP_DIV    = 8'd32;
  localparam logic [OP_W-1:0] OP_MUL    = 8'd33;
  localparam logic [OP_W-1:0] OP_MOD    = 8'd34;
  localparam logic [OP_W-1:0] OP_BR     = 8'd40;
  localparam logic [OP_W-1:0] OP_BRNEG  = 8'd41;
  localparam logic [OP_W-1:0] OP_BRZERO = 8'd42;
  localparam logic [OP_W-1:0] OP_HALT   = 8'd43;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_SPLIT,
    S_LOC,
    S_EXEC,
    S_MUL,
    S_DIV,
    S_CHECK,
    S_DONE
  } fsm_t;

endpackage

// File: hdl/dac_div.sv
module dac_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [dac_pkg::WORD_W-1:0]  dividend,
  input  logic signed [dac_pkg::WORD_W-1:0]  divisor,
  output logic                               done,
  output logic signed [dac_pkg::WORD_W-1:0]  quotient,
  output logic signed [dac_pkg::WORD_W-1:0]  remainder
);
  import dac_pkg::*;

  localparam int CNT_W = $clog2(WORD_W + 1);

  logic                busy;
  logic [CNT_W-1:0]    cnt;
  logic [WORD_W-1:0]   quo;
  logic [WORD_W-1:0]   rem;
  logic [WORD_W-1:0]   den;
  logic                neg_q;
  logic                neg_r;
  logic [WORD_W:0]     shifted;
  logic [WORD_W+1:0]   trial;
  logic [WORD_W-1:0]   mag_a;
  logic [WORD_W-1:0]   mag_b;

  // Restoring division on magnitudes, one quotient bit per cycle.
  assign mag_a   = dividend[WORD_W-1] ? WORD_W'(-dividend) : dividend;
  assign mag_b   = divisor[WORD_W-1] ? WORD_W'(-divisor) : divisor;
  assign shifted = {rem, quo[WORD_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(WORD_W);
    end else if (busy) begin
      if (cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
      end else begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= mag_a;
      rem   <= '0;
      den   <= mag_b;
      neg_q <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
      neg_r <= dividend[WORD_W-1];
    end else if (busy && cnt != '0) begin
      if (!trial[WORD_W+1]) begin
        rem <= trial[WORD_W-1:0];
        quo <= {quo[WORD_W-2:0], 1'b1};
      end else begin
        rem <= shifted[WORD_W-1:0];
        quo <= {quo[WORD_W-2:0], 1'b0};
      end
    end
  end

  // Truncating division: the remainder takes the sign of the dividend.
  assign done      = busy && (cnt == '0);
  assign quotient  = neg_q ? WORD_W'(-quo) : quo;
  assign remainder = neg_r ? WORD_W'(-rem) : rem;

endmodule

// File: hdl/decimal_accumulator_cpu.sv
// Decimal accumulator machine. Each input beat either loads one word into the
// MEM_WORDS-entry word memory (action 0) or executes one instruction (action 1),
// and every input beat produces exactly one result beat carrying the status,
// the program counter, the accumulator, any word emitted by a write
// instruction and a flag telling whether read_value was consumed. Words hold
// signed values within +/-WORD_LIMIT; an instruction is opcode * 100 + location.
// The block works on one item at a time. A step makes two dependent reads of
// the word memory through its single read port (instruction fetch, then
// operand), and a divide or modulus also waits for the divider, which retires
// one quotient bit per cycle. A finished result sits in an output register,
// so the next item is taken while the previous result is still stalled
// downstream. Memory reads as zero after reset through per-word valid flags,
// so no clearing pass is needed.
module decimal_accumulator_cpu #(
  parameter int MEM_WORDS  = 100,
  parameter int WORD_LIMIT = 9999
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  logic                               action,
  input  logic [dac_pkg::ADDR_W-1:0]         address,
  input  logic signed [dac_pkg::WORD_W-1:0]  load_value,
  input  logic signed [dac_pkg::WORD_W-1:0]  read_value,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic [2:0]                         status,
  output logic [dac_pkg::ADDR_W-1:0]         program_counter,
  output logic signed [dac_pkg::WORD_W-1:0]  accumulator_out,
  output logic                               write_valid,
  output logic signed [dac_pkg::WORD_W-1:0]  write_value,
  output logic                               read_taken
);
  import dac_pkg::*;

  localparam int MEM_AW = $clog2(MEM_WORDS);
  localparam logic [ADDR_W-1:0] MEM_END = ADDR_W'(MEM_WORDS);
  localparam logic signed [31:0] LIMIT = 32'(WORD_LIMIT);

  function automatic logic beyond(input logic signed [31:0] v);
    return (v > LIMIT) || (v < -LIMIT);
  endfunction

  // Architectural state. The word memory is written and read in clocked code.
  logic signed [WORD_W-1:0] mem [MEM_WORDS];
  logic [MEM_WORDS-1:0]     mem_ok;
  logic signed [WORD_W-1:0] acc;
  logic [ADDR_W-1:0]        pc;
  logic                     stopped;

  fsm_t state;
  fsm_t state_next;

  // Latched item fields.
  logic                     it_action;
  logic [ADDR_W-1:0]        it_addr;
  logic signed [WORD_W-1:0] it_load;
  logic signed [WORD_W-1:0] it_read;

  // Decode registers.
  logic [OP_W-1:0]          opcode;
  logic [ADDR_W-1:0]        loc;
  logic signed [2*WORD_W-1:0] prod;

  // Result under construction.
  status_t                  st;
  logic                     wr_valid;
  logic signed [WORD_W-1:0] wr_value;
  logic                     rd_taken;
  logic                     exec;

  // Memory port.
  logic                     rd_en;
  logic [MEM_AW-1:0]        rd_addr;
  logic signed [WORD_W-1:0] rd_data;
  logic                     rd_ok;
  logic                     mem_we;
  logic [MEM_AW-1:0]        wr_addr;
  logic signed [WORD_W-1:0] wr_data;

  // Divider.
  logic                     div_start;
  logic                     div_done;
  logic signed [WORD_W-1:0] div_quo;
  logic signed [WORD_W-1:0] div_rem;

  logic signed [WORD_W-1:0] word;
  logic [WORD_W-2:0]        word_mag;
  logic [WORD_W+RECIP_W-2:0] recip_prod;
  logic [WORD_W-2:0]        loc_full;
  logic signed [WORD_W:0]   sum;
  logic signed [WORD_W:0]   diff;
  logic signed [WORD_W-1:0] read_sat;
  logic                     load_ok;
  logic                     out_free;

  // A word that was never written reads as zero.
  assign word     = rd_ok ? rd_data : '0;
  assign word_mag = word[WORD_W-2:0];
  assign recip_prod = word_mag * DEC_RECIP;
  assign loc_full = word_mag - (WORD_W-1)'(opcode * 7'(DEC_BASE));

  assign sum  = {acc[WORD_W-1], acc} + {word[WORD_W-1], word};
  assign diff = {acc[WORD_W-1], acc} - {word[WORD_W-1], word};

  assign read_sat = (32'(it_read) > LIMIT)  ? WORD_W'(LIMIT) :
                    (32'(it_read) < -LIMIT) ? WORD_W'(-LIMIT) : it_read;
  assign load_ok  = (it_addr < MEM_END) && !beyond(32'(it_load));
  assign out_free = !result_valid || !result_stall;

  dac_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (acc),
    .divisor   (word),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Word memory with one registered read port and one write port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_ok <= '0;
      rd_ok  <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_ok <= mem_ok[rd_addr];
      end
      if (mem_we) begin
        mem_ok[wr_addr] <= 1'b1;
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          if (!action) begin
            state_next = S_LOAD;
          end else if (stopped || pc >= MEM_END) begin
            state_next = S_DONE;
          end else begin
            state_next = S_SPLIT;
          end
        end
      end
      S_LOAD:  state_next = S_DONE;
      S_SPLIT: state_next = word[WORD_W-1] ? S_CHECK : S_LOC;
      S_LOC:   state_next = (ADDR_W'(loc_full) >= MEM_END) ? S_CHECK : S_EXEC;
      S_EXEC: begin
        if (opcode == OP_MUL) begin
          state_next = S_MUL;
        end else if ((opcode == OP_DIV || opcode == OP_MOD) && word != '0) begin
          state_next = S_DIV;
        end else begin
          state_next = S_CHECK;
        end
      end
      S_MUL:   state_next = S_CHECK;
      S_DIV:   state_next = div_done ? S_CHECK : S_DIV;
      S_CHECK: state_next = S_DONE;
      S_DONE:  state_next = out_free ? S_IDLE : S_DONE;
      default: state_next = S_IDLE;
    endcase
  end

  // Control outputs: memory port, divider start and input stall.
  always_comb begin
    item_stall = 1'b1;
    rd_en      = 1'b0;
    rd_addr    = '0;
    mem_we     = 1'b0;
    wr_addr    = loc[MEM_AW-1:0];
    wr_data    = acc;
    div_start  = 1'b0;
    unique case (state)
      S_IDLE: begin
        item_stall = 1'b0;
        rd_en      = 1'b1;
        rd_addr    = (pc < MEM_END) ? pc[MEM_AW-1:0] : '0;
      end
      S_LOAD: begin
        mem_we  = load_ok;
        wr_addr = it_addr[MEM_AW-1:0];
        wr_data = it_load;
      end
      S_LOC: begin
        rd_en   = ADDR_W'(loc_full) < MEM_END;
        rd_addr = loc_full[MEM_AW-1:0];
      end
      S_EXEC: begin
        if (opcode == OP_READ) begin
          mem_we  = 1'b1;
          wr_data = read_sat;
        end else if (opcode == OP_STORE) begin
          mem_we  = 1'b1;
          wr_data = acc;
        end
        div_start = (opcode == OP_DIV || opcode == OP_MOD) && word != '0;
      end
      S_SPLIT, S_MUL, S_DIV, S_CHECK, S_DONE: begin
        item_stall = 1'b1;
      end
      default: begin
        item_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Item fields are captured on the accepted beat.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && item_valid) begin
      it_action <= action;
      it_addr   <= address;
      it_load   <= load_value;
      it_read   <= read_value;
    end
  end

  // Decode: the quotient by 100 first, then the location from it; the execute state also registers the product.
  always_ff @(posedge clk) begin
    if (state == S_SPLIT) begin
      opcode <= recip_prod[WORD_W+RECIP_W-2:DEC_SHIFT];
    end
    if (state == S_LOC) begin
      loc <= ADDR_W'(loc_full);
    end
    if (state == S_EXEC) begin
      prod <= acc * word;
    end
  end

  // Machine state and the result being assembled.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      pc       <= '0;
      stopped  <= 1'b0;
      st       <= ST_RUN;
      wr_valid <= 1'b0;
      wr_value <= '0;
      rd_taken <= 1'b0;
      exec     <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            st       <= ST_RUN;
            wr_valid <= 1'b0;
            wr_value <= '0;
            rd_taken <= 1'b0;
            exec     <= 1'b0;
            if (action) begin
              if (stopped || pc >= MEM_END) begin
                stopped <= 1'b1;
                st      <= ST_IDLE;
              end else begin
                exec <= 1'b1;
              end
            end
          end
        end
        S_LOAD: begin
          st <= stopped ? ST_IDLE : ST_RUN;
        end
        S_SPLIT: begin
          pc <= pc + ADDR_W'(1);
          if (word[WORD_W-1]) begin
            st      <= ST_BADOP;
            stopped <= 1'b1;
            pc      <= MEM_END;
          end
        end
        S_LOC: begin
          if (ADDR_W'(loc_full) >= MEM_END) begin
            st      <= ST_END;
            stopped <= 1'b1;
            pc      <= MEM_END;
          end
        end
        S_EXEC: begin
          unique case (opcode)
            OP_READ: begin
              rd_taken <= 1'b1;
            end
            OP_WRITE: begin
              wr_valid <= 1'b1;
              wr_value <= word;
            end
            OP_LOAD: begin
              acc <= word;
            end
            OP_STORE, OP_MUL: begin
              acc <= acc;
            end
            OP_ADD: begin
              if (beyond(32'(sum))) begin
                acc     <= '0;
                st      <= ST_OVF;
                stopped <= 1'b1;
                pc      <= MEM_END;
              end else begin
                acc <= WORD_W'(sum);
              end
            end
            OP_SUB: begin
              if (beyond(32'(diff))) begin
                acc     <= '0;
                st      <= ST_OVF;
                stopped <= 1'b1;
                pc      <= MEM_END;
              end else begin
                acc <= WORD_W'(diff);
              end
            end
            OP_DIV, OP_MOD: begin
              if (word == '0) begin
                st      <= ST_DIV0;
                stopped <= 1'b1;
                pc      <= MEM_END;
              end
            end
            OP_BR: begin
              pc <= loc;
            end
            OP_BRNEG: begin
              if (acc[WORD_W-1]) begin
                pc <= loc;
              end
            end
            OP_BRZERO: begin
              if (acc == '0) begin
                pc <= loc;
              end
            end
            OP_HALT: begin
              st      <= ST_HALT;
              stopped <= 1'b1;
              pc      <= MEM_END;
            end
            default: begin
              st      <= ST_BADOP;
              stopped <= 1'b1;
              pc      <= MEM_END;
            end
          endcase
        end
        S_MUL: begin
          if (beyond(32'(prod))) begin
            acc     <= '0;
            st      <= ST_OVF;
            stopped <= 1'b1;
            pc      <= MEM_END;
          end else begin
            acc <= WORD_W'(prod);
          end
        end
        S_DIV: begin
          if (div_done) begin
            acc <= (opcode == OP_MOD) ? div_rem : div_quo;
          end
        end
        S_CHECK: begin
          // A step that runs past the last word stops the machine.
          if (exec && it_action && !stopped && pc >= MEM_END) begin
            st      <= ST_END;
            stopped <= 1'b1;
            pc      <= MEM_END;
          end
        end
        default: begin
          acc <= acc;
        end
      endcase
    end
  end

  // Output register: a finished result waits here for the consumer.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      status          <= st;
      program_counter <= pc;
      accumulator_out <= acc;
      write_valid     <= wr_valid;
      write_value     <= wr_value;
      read_taken      <= rd_taken;
    end
  end

endmodule

// File: bench/tb_decimal_accumulator_cpu.sv
module tb_decimal_accumulator_cpu;
  import dac_pkg::*;

  // The block is built with the default memory size and word limit. The
  // machine model below uses the same two numbers.
  localparam int MEM_WORDS  = 100;
  localparam int WORD_LIMIT = 9999;

  // Kinds of input beat.
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  // Stimulus shape: how many counted beats to send and when the run starts
  // to bring the machine to its single final stop.
  localparam int BEAT_TARGET = 1550;
  localparam int ENDING_AT   = 1500;
  localparam int LONG_HOLD   = 200;
  localparam int DRAIN_LIMIT = 20000;

  // One input beat and one result beat, at the widths of the ports.
  typedef struct packed {
    logic                     action;
    logic [ADDR_W-1:0]        address;
    logic signed [WORD_W-1:0] load_value;
    logic signed [WORD_W-1:0] read_value;
  } machine_beat_t;

  typedef struct packed {
    status_t                  status;
    logic [ADDR_W-1:0]        pc;
    logic signed [WORD_W-1:0] acc;
    logic                     write_valid;
    logic signed [WORD_W-1:0] write_value;
    logic                     read_taken;
  } machine_outcome_t;

  // The scoreboard carries its own copy of the machine: word memory,
  // accumulator, program counter and the stopped flag. Every accepted input
  // beat is run through that copy, and the outcome waits in a queue for the
  // matching result beat.
  class machine_scoreboard;
    int words[MEM_WORDS];
    int acc;
    int pc;
    bit halted;
    int errors;
    machine_outcome_t pending_outcomes[$];

    function new();
      foreach (words[i]) words[i] = 0;
      acc = 0;
      pc = 0;
      halted = 1'b0;
      errors = 0;
    endfunction

    // Works out the outcome of one beat. The machine state is updated only
    // when commit is set, so the stimulus side can also try a beat out.
    function machine_outcome_t execute_beat(machine_beat_t it, bit commit);
      machine_outcome_t r;
      int acc_n, pc_n, v, m, w, loc, put_addr, put_val;
      logic [OP_W-1:0] op;
      bit stop_n;
      r = '0;
      r.status = ST_RUN;
      acc_n = acc;
      pc_n = pc;
      stop_n = halted;
      put_addr = -1;
      put_val = 0;
      if (it.action == ACT_LOAD) begin
        // Words outside the memory or outside the word range are dropped.
        v = it.load_value;
        if (it.address < MEM_WORDS && v <= WORD_LIMIT && v >= -WORD_LIMIT) begin
          put_addr = it.address;
          put_val = v;
        end
        if (halted) r.status = ST_IDLE;
      end else if (halted || pc >= MEM_WORDS) begin
        stop_n = 1'b1;
        r.status = ST_IDLE;
      end else begin
        w = words[pc];
        pc_n = pc + 1;
        if (w < 0) begin
          r.status = ST_BADOP;
          stop_n = 1'b1;
        end else begin
          op = OP_W'(w / DEC_BASE);
          loc = w % DEC_BASE;
          if (loc >= MEM_WORDS) begin
            r.status = ST_END;
            stop_n = 1'b1;
          end else begin
            m = words[loc];
            case (op)
              OP_READ: begin
                v = it.read_value;
                if (v > WORD_LIMIT) v = WORD_LIMIT;
                if (v < -WORD_LIMIT) v = -WORD_LIMIT;
                put_addr = loc;
                put_val = v;
                r.read_taken = 1'b1;
              end
              OP_WRITE: begin
                r.write_valid = 1'b1;
                r.write_value = WORD_W'(m);
              end
              OP_LOAD: acc_n = m;
              OP_STORE: begin
                put_addr = loc;
                put_val = acc;
              end
              OP_ADD, OP_SUB, OP_MUL: begin
                v = (op == OP_ADD) ? acc + m : (op == OP_SUB) ? acc - m : acc * m;
                if (v > WORD_LIMIT || v < -WORD_LIMIT) begin
                  acc_n = 0;
                  r.status = ST_OVF;
                  stop_n = 1'b1;
                end else begin
                  acc_n = v;
                end
              end
              OP_DIV, OP_MOD: begin
                if (m == 0) begin
                  r.status = ST_DIV0;
                  stop_n = 1'b1;
                end else begin
                  acc_n = (op == OP_DIV) ? acc / m : acc % m;
                end
              end
              OP_BR: pc_n = loc;
              OP_BRNEG: if (acc < 0) pc_n = loc;
              OP_BRZERO: if (acc == 0) pc_n = loc;
              OP_HALT: begin
                r.status = ST_HALT;
                stop_n = 1'b1;
              end
              default: begin
                r.status = ST_BADOP;
                stop_n = 1'b1;
              end
            endcase
          end
        end
        // Falling off the last word stops the machine as well.
        if (!stop_n && pc_n >= MEM_WORDS) begin
          r.status = ST_END;
          stop_n = 1'b1;
        end
        if (stop_n) pc_n = MEM_WORDS;
      end
      r.pc = ADDR_W'(pc_n);
      r.acc = WORD_W'(acc_n);
      if (commit) begin
        if (put_addr >= 0) words[put_addr] = put_val;
        acc = acc_n;
        pc = pc_n;
        halted = stop_n;
      end
      return r;
    endfunction

    function void take_beat(machine_beat_t it);
      pending_outcomes.push_back(execute_beat(it, 1'b1));
    endfunction

    // Tells whether a step with this word at the program counter leaves the
    // machine running. Memory is left as it was.
    function bit keeps_running(int word, logic signed [WORD_W-1:0] rv);
      machine_beat_t probe;
      machine_outcome_t r;
      int saved;
      if (halted || pc >= MEM_WORDS) return 1'b0;
      saved = words[pc];
      words[pc] = word;
      probe = '0;
      probe.action = ACT_STEP;
      probe.read_value = rv;
      r = execute_beat(probe, 1'b0);
      words[pc] = saved;
      return r.status == ST_RUN;
    endfunction

    function void report(string field, int want, int seen);
      $display("%0t: %s expected %0d, got %0d", $time, field, want, seen);
      errors++;
    endfunction

    function void check_outcome(machine_outcome_t seen);
      machine_outcome_t want;
      if (pending_outcomes.size() == 0) begin
        $display("%0t: result beat with nothing pending (status %0d, pc %0d)",
                 $time, seen.status, seen.pc);
        errors++;
        return;
      end
      want = pending_outcomes.pop_front();
      if (seen.status != want.status) report("status", want.status, seen.status);
      if (seen.pc != want.pc) report("program_counter", want.pc, seen.pc);
      if (seen.acc != want.acc) report("accumulator_out", want.acc, seen.acc);
      if (seen.write_valid != want.write_valid)
        report("write_valid", want.write_valid, seen.write_valid);
      if (seen.write_value != want.write_value)
        report("write_value", want.write_value, seen.write_value);
      if (seen.read_taken != want.read_taken)
        report("read_taken", want.read_taken, seen.read_taken);
    endfunction

    function int outstanding();
      return pending_outcomes.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic item_valid;
  logic item_stall;
  logic action;
  logic [ADDR_W-1:0] address;
  logic signed [WORD_W-1:0] load_value;
  logic signed [WORD_W-1:0] read_value;
  logic result_valid;
  logic result_stall;
  logic [2:0] status;
  logic [ADDR_W-1:0] program_counter;
  logic signed [WORD_W-1:0] accumulator_out;
  logic write_valid;
  logic signed [WORD_W-1:0] write_value;
  logic read_taken;

  machine_scoreboard sb = new();

  // Counted beats (loads that the block drops are left out of the count).
  int beats_counted = 0;
  // Beats still to be sent back to back, with no gap on the input side.
  int burst_left = 0;
  // Set by the stimulus to ask the result side for one long hold-off.
  bit hold_req = 1'b0;
  // While set, neither side idles.
  bit quiet = 1'b0;

  // Instructions that keep the machine going, given the right operands.
  logic [OP_W-1:0] running_ops[12] = '{OP_READ, OP_WRITE, OP_LOAD, OP_STORE,
                                       OP_ADD, OP_SUB, OP_DIV, OP_MUL, OP_MOD,
                                       OP_BR, OP_BRNEG, OP_BRZERO};

  decimal_accumulator_cpu #(
    .MEM_WORDS (MEM_WORDS),
    .WORD_LIMIT(WORD_LIMIT)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .action         (action),
    .address        (address),
    .load_value     (load_value),
    .read_value     (read_value),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .status         (status),
    .program_counter(program_counter),
    .accumulator_out(accumulator_out),
    .write_valid    (write_valid),
    .write_value    (write_value),
    .read_taken     (read_taken)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int instr(logic [OP_W-1:0] op, int loc);
    return int'(op) * DEC_BASE + loc;
  endfunction

  // Idle lengths: mostly none or a few cycles, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 88) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  // Data words lean toward small values so that arithmetic rarely overflows,
  // with the range ends and the full range mixed in.
  function automatic int pick_data();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(0, 60) - 30;
    else if (r < 60) return WORD_LIMIT;
    else if (r < 70) return -WORD_LIMIT;
    else if (r < 75) return 0;
    else return $urandom_range(0, 2 * WORD_LIMIT) - WORD_LIMIT;
  endfunction

  // Read values are mostly in range; the rest cover every 15-bit pattern,
  // which the block has to saturate.
  function automatic logic signed [WORD_W-1:0] pick_read();
    int v;
    if ($urandom_range(0, 9) < 7) begin
      v = $urandom_range(0, 2 * WORD_LIMIT) - WORD_LIMIT;
      return WORD_W'(v);
    end
    return WORD_W'($urandom);
  endfunction

  // Picks an instruction for the current program counter that keeps the
  // machine running. If nothing random fits, a jump back into memory does.
  function automatic int pick_running_word(logic signed [WORD_W-1:0] rv);
    int word;
    int tries;
    for (tries = 0; tries < 12; tries++) begin
      word = instr(running_ops[$urandom_range(0, 11)], $urandom_range(0, MEM_WORDS - 1));
      if (sb.keeps_running(word, rv)) return word;
    end
    return instr(OP_BR, $urandom_range(0, MEM_WORDS - 2));
  endfunction

  task automatic idle_input(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      item_valid <= 1'b0;
    end
  endtask

  // Offers one beat from the falling edge on and holds it until the rising
  // edge that takes it. The model sees the beat in that same step, so the
  // next beat is chosen from the state that the block will have.
  task automatic send_beat(machine_beat_t b, bit counted);
    @(negedge clk);
    item_valid <= 1'b1;
    action <= b.action;
    address <= b.address;
    load_value <= b.load_value;
    read_value <= b.read_value;
    do @(posedge clk); while (item_stall);
    sb.take_beat(b);
    if (counted) beats_counted++;
    if (burst_left > 0) burst_left--;
    else if (!quiet) idle_input(pick_gap());
  endtask

  task automatic load_word(logic [ADDR_W-1:0] addr, logic signed [WORD_W-1:0] val);
    machine_beat_t b;
    b.action = ACT_LOAD;
    b.address = addr;
    b.load_value = val;
    b.read_value = WORD_W'($urandom);
    send_beat(b, addr < MEM_WORDS && val <= WORD_LIMIT && val >= -WORD_LIMIT);
  endtask

  task automatic step_machine(logic signed [WORD_W-1:0] rv);
    machine_beat_t b;
    b.action = ACT_STEP;
    b.address = ADDR_W'($urandom);
    b.load_value = WORD_W'($urandom);
    b.read_value = rv;
    send_beat(b, 1'b1);
  endtask

  // Puts an instruction where the program counter points and runs it.
  task automatic exec_at_pc(int word, logic signed [WORD_W-1:0] rv);
    load_word(ADDR_W'(sb.pc), WORD_W'(word));
    step_machine(rv);
  endtask

  // Drops valid and waits until every outstanding result has come back.
  task automatic drain_results();
    int waited;
    waited = 0;
    @(negedge clk);
    item_valid <= 1'b0;
    while (sb.outstanding() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
  endtask

  // A short fixed program. Loads that must be dropped come first: an address
  // past the end of memory, and the largest and most negative 15-bit words.
  // The program then reads both range ends through saturation, writes a word
  // out, takes a branch on negative and one on zero, and goes through
  // subtract, multiply, modulus and divide with negative operands.
  task automatic run_fixed_program();
    load_word(7'h7F, 15'sd321);
    load_word(7'd10, 15'h3FFF);
    load_word(7'd11, 15'h4000);
    load_word(7'd0, WORD_W'(instr(OP_READ, 90)));
    load_word(7'd1, WORD_W'(instr(OP_READ, 91)));
    load_word(7'd2, WORD_W'(instr(OP_WRITE, 90)));
    load_word(7'd3, WORD_W'(instr(OP_LOAD, 91)));
    load_word(7'd4, WORD_W'(instr(OP_BRNEG, 6)));
    load_word(7'd6, WORD_W'(instr(OP_ADD, 90)));
    load_word(7'd7, WORD_W'(instr(OP_BRZERO, 9)));
    load_word(7'd9, WORD_W'(instr(OP_READ, 92)));
    load_word(7'd10, WORD_W'(instr(OP_SUB, 92)));
    load_word(7'd11, WORD_W'(instr(OP_MUL, 92)));
    load_word(7'd12, WORD_W'(instr(OP_MOD, 90)));
    load_word(7'd13, WORD_W'(instr(OP_DIV, 92)));
    step_machine(15'h3FFF);
    step_machine(15'h4000);
    repeat (5) step_machine(pick_read());
    step_machine(-15'sd4);
    repeat (4) step_machine(pick_read());
  endtask

  // One random transaction while the machine is running: a load of a data
  // word, a stray load that the block may drop, or a step. A step either
  // runs whatever word sits at the program counter, when that is safe, or
  // first plants a random instruction there that keeps the machine running.
  task automatic random_transaction();
    int r;
    logic signed [WORD_W-1:0] rv;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      if ($urandom_range(0, 1) == 0)
        load_word(ADDR_W'($urandom_range(MEM_WORDS, 127)), WORD_W'($urandom));
      else
        load_word(ADDR_W'($urandom_range(0, MEM_WORDS - 1)), WORD_W'($urandom));
    end else if (r < 36) begin
      load_word(ADDR_W'($urandom_range(0, MEM_WORDS - 1)), WORD_W'(pick_data()));
    end else begin
      rv = pick_read();
      if ($urandom_range(0, 3) == 0 && sb.keeps_running(sb.words[sb.pc], rv))
        step_machine(rv);
      else
        exec_at_pc(pick_running_word(rv), rv);
    end
  endtask

  // Stopping is final, since reset comes only once, so each run ends the
  // program in one way picked at random: halt, unknown opcode, negative
  // instruction word, overflow of add, subtract or multiply, divide or
  // modulus by zero, or running past the last word.
  task automatic stop_the_machine();
    int op;
    exec_at_pc(instr(OP_BR, 10), pick_read());
    case ($urandom_range(0, 8))
      0: exec_at_pc(instr(OP_HALT, $urandom_range(0, MEM_WORDS - 1)), pick_read());
      1: begin
        do op = $urandom_range(0, 99);
        while (op inside {OP_READ, OP_WRITE, OP_LOAD, OP_STORE, OP_ADD, OP_SUB,
                          OP_DIV, OP_MUL, OP_MOD, OP_BR, OP_BRNEG, OP_BRZERO,
                          OP_HALT});
        exec_at_pc(instr(OP_W'(op), $urandom_range(0, MEM_WORDS - 1)), pick_read());
      end
      2: exec_at_pc(-$urandom_range(1, WORD_LIMIT), pick_read());
      3: begin
        load_word(7'd60, WORD_W'(WORD_LIMIT));
        exec_at_pc(instr(OP_LOAD, 60), pick_read());
        exec_at_pc(instr(OP_ADD, 60), pick_read());
      end
      4: begin
        load_word(7'd60, WORD_W'(-WORD_LIMIT));
        load_word(7'd61, WORD_W'(WORD_LIMIT));
        exec_at_pc(instr(OP_LOAD, 60), pick_read());
        exec_at_pc(instr(OP_SUB, 61), pick_read());
      end
      5: begin
        load_word(7'd60, WORD_W'($urandom_range(101, WORD_LIMIT)));
        exec_at_pc(instr(OP_LOAD, 60), pick_read());
        exec_at_pc(instr(OP_MUL, 60), pick_read());
      end
      6: begin
        load_word(7'd61, 15'sd0);
        exec_at_pc(instr(OP_DIV, 61), pick_read());
      end
      7: begin
        load_word(7'd61, 15'sd0);
        exec_at_pc(instr(OP_MOD, 61), pick_read());
      end
      default: begin
        // A jump to the last word, then an ordinary instruction there.
        exec_at_pc(instr(OP_BR, MEM_WORDS - 1), pick_read());
        exec_at_pc(instr(OP_WRITE, $urandom_range(0, MEM_WORDS - 1)), pick_read());
      end
    endcase
  endtask

  // Result side: random stretches of stall and no stall, one long hold-off
  // on request, and no stall at all while the quiet window is open.
  initial begin : result_side
    int run_left;
    int hold_left;
    bit stall_now;
    run_left = 0;
    hold_left = 0;
    stall_now = 1'b0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (quiet) begin
        result_stall <= 1'b0;
      end else begin
        if (run_left == 0) begin
          stall_now = ($urandom_range(0, 2) == 0);
          run_left = stall_now ? pick_gap() + 1 : $urandom_range(1, 16);
        end
        run_left--;
        result_stall <= stall_now;
      end
    end
  end

  // Every result beat taken at a rising edge goes to the scoreboard.
  always @(posedge clk) begin
    machine_outcome_t seen;
    if (!rst && result_valid && !result_stall) begin
      seen.status = status_t'(status);
      seen.pc = program_counter;
      seen.acc = accumulator_out;
      seen.write_valid = write_valid;
      seen.write_value = write_value;
      seen.read_taken = read_taken;
      sb.check_outcome(seen);
    end
  end

  initial begin : stimulus
    bit hold_done;
    bit pause_done;
    hold_done = 1'b0;
    pause_done = 1'b0;
    rst = 1'b1;
    item_valid = 1'b0;
    action = ACT_LOAD;
    address = '0;
    load_value = '0;
    read_value = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_fixed_program();

    while (beats_counted < ENDING_AT) begin
      // Once, the result side holds off for a long time while beats keep
      // coming back to back, so the block fills up and stalls its input.
      if (!hold_done && beats_counted >= 400) begin
        hold_done = 1'b1;
        hold_req = 1'b1;
        burst_left = 80;
      end
      // Once, the input side waits until every result is back.
      if (!pause_done && beats_counted >= 800) begin
        pause_done = 1'b1;
        drain_results();
      end
      quiet = (beats_counted >= 1000 && beats_counted < 1120);
      random_transaction();
    end
    quiet = 1'b0;

    drain_results();
    stop_the_machine();

    // After the stop, steps report idle and loads still write memory.
    while (beats_counted < BEAT_TARGET) begin
      if ($urandom_range(0, 1) == 0)
        step_machine(pick_read());
      else
        load_word(ADDR_W'($urandom_range(0, MEM_WORDS - 1)), WORD_W'(pick_data()));
    end

    drain_results();
    // The wait below leaves room for any stray result beat to show up.
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #8_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
